// ----- rtl/ttag_pkg.sv -----
// Shared constants, types and helpers for the transpose address generator.
package ttag_pkg;

    localparam int MAX_DIMS   = 4;
    localparam int INDEX_BITS = 32;
    localparam int DIM_BITS   = 16;
    localparam int RANK_BITS  = 3;
    localparam int AXIS_BITS  = 2;
    localparam int MAP_BITS   = AXIS_BITS * MAX_DIMS;
    localparam int CFG_IDX_BITS  = 3;
    localparam int CFG_DATA_BITS = DIM_BITS;
    localparam int CNT_BITS   = $clog2(MAX_DIMS + 1);

    typedef enum logic [CFG_IDX_BITS-1:0] {
        REG_RANK     = 3'd0,
        REG_DIM_0    = 3'd1,
        REG_DIM_1    = 3'd2,
        REG_DIM_2    = 3'd3,
        REG_DIM_3    = 3'd4,
        REG_AXIS_MAP = 3'd5
    } cfg_idx_t;

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_CALC = 2'b10
    } state_t;

    // Per-cell odometer control
    typedef struct packed {
        logic clear;
        logic step;
    } cell_ctrl_t;

    // A size of zero behaves as one
    function automatic logic [DIM_BITS-1:0] dim_fix(input logic [DIM_BITS-1:0] d);
        dim_fix = (d == '0) ? DIM_BITS'(1) : d;
    endfunction

endpackage

// ----- rtl/tensor_transpose_address_gen.sv -----
// Top level: N-d transpose address generator built from a row of axis cells.
// A request is taken only while idle; its result passes the 4-stage Horner chain of the cells
// and is loaded into the output register once that is free, before the next request is taken.
// A finished result may wait in the output register while the next request is taken.
// Reset (async, active low): coordinates and counter zero, rank 4, sizes 1, identity map.
module tensor_transpose_address_gen (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic [ttag_pkg::CFG_IDX_BITS-1:0]    cfg_index,
    input  logic [ttag_pkg::CFG_DATA_BITS-1:0]   cfg_data,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic                                restart,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic [ttag_pkg::INDEX_BITS-1:0]      dst_index,
    output logic [ttag_pkg::INDEX_BITS-1:0]      src_index,
    output logic                                last
);
    import ttag_pkg::*;

    // configuration
    logic [RANK_BITS-1:0] rank_reg;
    logic [DIM_BITS-1:0]  dim_size_reg [MAX_DIMS];
    logic [MAP_BITS-1:0]  axis_map_reg;

    // control
    state_t                state_reg, state_next;
    logic [CNT_BITS-1:0]   cnt_reg, cnt_next;
    logic [INDEX_BITS-1:0] counter_reg, counter_next;
    logic                  out_valid_reg, out_valid_next;
    logic [INDEX_BITS-1:0] dst_index_reg, src_index_reg;
    logic                  last_reg;

    logic                  accept;
    logic                  finish;
    logic                  last_now;
    logic [RANK_BITS-1:0]  eff_rank;
    cell_ctrl_t            cell_ctrl;

    logic [MAX_DIMS:0]     carry;
    logic [INDEX_BITS-1:0] acc [MAX_DIMS+1];
    logic [DIM_BITS-1:0]   coords [MAX_DIMS];
    logic [DIM_BITS-1:0]   scoord [MAX_DIMS];
    logic [DIM_BITS-1:0]   src_dim [MAX_DIMS];
    logic [DIM_BITS-1:0]   dst_dim [MAX_DIMS];
    logic [MAX_DIMS-1:0]   active;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rank_reg     <= RANK_BITS'(MAX_DIMS);
            axis_map_reg <= MAP_BITS'(228);
            for (int k = 0; k < MAX_DIMS; k++)
                dim_size_reg[k] <= DIM_BITS'(1);
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_RANK:     rank_reg        <= cfg_data[RANK_BITS-1:0];
                REG_DIM_0:    dim_size_reg[0] <= cfg_data;
                REG_DIM_1:    dim_size_reg[1] <= cfg_data;
                REG_DIM_2:    dim_size_reg[2] <= cfg_data;
                REG_DIM_3:    dim_size_reg[3] <= cfg_data;
                REG_AXIS_MAP: axis_map_reg    <= cfg_data[MAP_BITS-1:0];
                default:      ;
            endcase
        end
    end

    // rank zero acts as one, above MAX_DIMS saturates
    always_comb
    begin
        priority if (rank_reg == '0)
            eff_rank = RANK_BITS'(1);
        else if (rank_reg > RANK_BITS'(MAX_DIMS))
            eff_rank = RANK_BITS'(MAX_DIMS);
        else
            eff_rank = rank_reg;
    end

    // scatter destination coordinates onto source axes; a later destination axis wins
    always_comb
    begin
        for (int j = 0; j < MAX_DIMS; j++)
        begin
            active[j]  = RANK_BITS'(j) < eff_rank;
            src_dim[j] = dim_fix(dim_size_reg[j]);
            dst_dim[j] = dim_fix(dim_size_reg[axis_map_reg[AXIS_BITS*j +: AXIS_BITS]]);
            scoord[j]  = '0;
            for (int i = 0; i < MAX_DIMS; i++)
            begin
                if (RANK_BITS'(i) < eff_rank && RANK_BITS'(j) < eff_rank &&
                    axis_map_reg[AXIS_BITS*i +: AXIS_BITS] == AXIS_BITS'(j))
                    scoord[j] = coords[i];
            end
        end
    end

    assign carry[MAX_DIMS] = 1'b1;
    assign acc[0]          = '0;
    assign last_now        = carry[0];

    for (genvar g = 0; g < MAX_DIMS; g++)
    begin : g_cell
        ttag_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .active    (active[g]),
            .ctrl      (cell_ctrl),
            .carry_in  (carry[g+1]),
            .carry_out (carry[g]),
            .dst_dim   (dst_dim[g]),
            .src_dim   (src_dim[g]),
            .scoord    (scoord[g]),
            .acc_in    (acc[g]),
            .acc_out   (acc[g+1]),
            .coord     (coords[g])
        );
    end

    assign in_ready = (state_reg == ST_IDLE);
    assign accept   = in_valid && in_ready;
    assign finish   = (state_reg == ST_CALC) && (cnt_reg == CNT_BITS'(MAX_DIMS)) &&
                      (!out_valid_reg || out_ready);

    assign cell_ctrl.clear = (accept && restart) || (finish && last_now);
    assign cell_ctrl.step  = finish && !last_now;

    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        counter_next   = counter_reg;
        out_valid_next = out_valid_reg;

        if (out_valid_reg && out_ready)
            out_valid_next = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = ST_CALC;
                    cnt_next   = '0;
                    if (restart)
                        counter_next = '0;
                end
            end
            ST_CALC:
            begin
                if (cnt_reg != CNT_BITS'(MAX_DIMS))
                    cnt_next = cnt_reg + CNT_BITS'(1);
                if (finish)
                begin
                    state_next     = ST_IDLE;
                    out_valid_next = 1'b1;
                    counter_next   = last_now ? '0 : counter_reg + INDEX_BITS'(1);
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= '0;
            counter_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            counter_reg   <= counter_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (finish)
        begin
            dst_index_reg <= counter_reg;
            src_index_reg <= acc[MAX_DIMS];
            last_reg      <= last_now;
        end
    end

    assign out_valid = out_valid_reg;
    assign dst_index = dst_index_reg;
    assign src_index = src_index_reg;
    assign last      = last_reg;

    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> !in_ready)
        else $error("request taken while a previous one is still in flight");

    a_restart_clears: assert property (@(posedge clk) disable iff (!rst_n)
        accept && restart |=> counter_reg == '0 && coords[0] == '0 && coords[MAX_DIMS-1] == '0)
        else $error("restart did not clear the odometer");

    a_last_wraps: assert property (@(posedge clk) disable iff (!rst_n)
        finish && last_now |=> counter_reg == '0 && last && out_valid)
        else $error("final element did not wrap the odometer");

    a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == ST_CALC))
        else $error("result raised outside the calculation phase");

endmodule

// ----- rtl/ttag_cell.sv -----
// One axis cell: destination coordinate digit and one Horner stage.
module ttag_cell (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           active,
    input  ttag_pkg::cell_ctrl_t           ctrl,
    input  logic                           carry_in,
    output logic                           carry_out,
    input  logic [ttag_pkg::DIM_BITS-1:0]   dst_dim,
    input  logic [ttag_pkg::DIM_BITS-1:0]   src_dim,
    input  logic [ttag_pkg::DIM_BITS-1:0]   scoord,
    input  logic [ttag_pkg::INDEX_BITS-1:0] acc_in,
    output logic [ttag_pkg::INDEX_BITS-1:0] acc_out,
    output logic [ttag_pkg::DIM_BITS-1:0]   coord
);
    import ttag_pkg::*;

    logic [DIM_BITS-1:0]            coord_reg;
    logic [DIM_BITS-1:0]            coord_next;
    logic [DIM_BITS:0]              coord_inc;
    logic                           wrap;
    logic [INDEX_BITS+DIM_BITS-1:0] prod;
    logic [INDEX_BITS-1:0]          acc_reg;
    logic [INDEX_BITS-1:0]          acc_next;

    assign coord_inc = {1'b0, coord_reg} + (DIM_BITS+1)'(1);
    assign wrap      = coord_inc >= {1'b0, dst_dim};
    assign carry_out = active ? (carry_in & wrap) : carry_in;

    always_comb
    begin
        coord_next = coord_reg;
        priority if (ctrl.clear)
        begin
            coord_next = '0;
        end
        else if (ctrl.step && active && carry_in)
        begin
            coord_next = wrap ? '0 : coord_inc[DIM_BITS-1:0];
        end
        else
        begin
            coord_next = coord_reg;
        end
    end

    // Horner stage: acc * size + coordinate, modulo 2^INDEX_BITS
    assign prod = {{DIM_BITS{1'b0}}, acc_in} * {{INDEX_BITS{1'b0}}, src_dim};

    always_comb
    begin
        if (active)
            acc_next = prod[INDEX_BITS-1:0] + {{(INDEX_BITS-DIM_BITS){1'b0}}, scoord};
        else
            acc_next = acc_in;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            coord_reg <= '0;
        else
            coord_reg <= coord_next;
    end

    always_ff @(posedge clk)
    begin
        acc_reg <= acc_next;
    end

    assign acc_out = acc_reg;
    assign coord   = coord_reg;

endmodule
